// File: rtl/core/icrc_pkg.sv
// shared constants, types and helpers for the icmp receive checker
package icrc_pkg;

	localparam int HEADER_BYTES = 8;
	localparam int COUNT_W = 16;
	localparam int SUM_W = 16;
	localparam int HDR_IDX_W = $clog2(HEADER_BYTES);

	localparam logic [SUM_W-1:0] SUM_GOOD = 16'hFFFF;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;
	localparam logic [COUNT_W-1:0] COUNT_WRAP = 16'hFFFE;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = QPTR_W + 1;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_SHORT    = 2'd1,
		STATUS_MISMATCH = 2'd2
	} status_t;

	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_VERDICT = 1'b1
	} kind_t;

	// one classified item handed from the front to the back
	typedef struct packed {
		logic        has_payload;
		logic        has_verdict;
		logic [7:0]  data_byte;
		status_t     status;
		logic [7:0]  msg_type;
		logic [7:0]  msg_code;
		logic [15:0] checksum_field;
		logic [31:0] rest_word;
	} work_t;

	// ones' complement add with end-around carry
	function automatic logic [SUM_W-1:0] oc_add(input logic [SUM_W-1:0] a,
		input logic [SUM_W-1:0] b);
		logic [SUM_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[SUM_W-1:0] + {{(SUM_W-1){1'b0}}, s[SUM_W]};
	endfunction

endpackage

// File: rtl/core/icrc_in_if.sv
// input channel: one message byte per item
interface icrc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_message;

	modport source(output valid, output data_byte, output end_of_message, input ready);
	modport sink(input valid, input data_byte, input end_of_message, output ready);
endinterface

// File: rtl/core/icrc_out_if.sv
// output channel: forwarded payload bytes and end-of-message verdicts
interface icrc_out_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  payload_byte;
	logic [7:0]  msg_type;
	logic [7:0]  msg_code;
	logic [15:0] checksum_field;
	logic [31:0] rest_word;
	logic [1:0]  status;
	logic        run_last;

	modport source(output valid, output kind, output payload_byte, output msg_type,
		output msg_code, output checksum_field, output rest_word, output status,
		output run_last, input ready);
	modport sink(input valid, input kind, input payload_byte, input msg_type,
		input msg_code, input checksum_field, input rest_word, input status,
		input run_last, output ready);
endinterface

// File: rtl/core/icrc_front.sv
// front end: byte count, checksum accumulation, header capture, classification
module icrc_front (
	input  logic           clk,
	input  logic           arst_n,
	icrc_in_if.sink        msg,
	input  logic           queue_full,
	output logic           push,
	output icrc_pkg::work_t push_data
);
	import icrc_pkg::*;

	logic [COUNT_W-1:0] count_q;
	logic [SUM_W-1:0]   sum_q;
	logic [7:0]         held_q;
	logic [7:0]         type_q;
	logic [7:0]         code_q;
	logic [15:0]        cksum_q;
	logic [31:0]        rest_q;

	logic [7:0]         type_n;
	logic [7:0]         code_n;
	logic [15:0]        cksum_n;
	logic [31:0]        rest_n;

	logic               accept;
	logic               odd;
	logic               in_header;
	logic               is_payload;
	logic [SUM_W-1:0]   word;
	logic [SUM_W-1:0]   total;
	status_t            status;
	logic [7:0]         b;

	assign b          = msg.data_byte;
	assign msg.ready  = !queue_full;
	assign accept     = msg.valid && msg.ready;
	assign odd        = count_q[0];
	assign in_header  = count_q < COUNT_W'(HEADER_BYTES);
	assign is_payload = !in_header;
	assign word       = odd ? {held_q, b} : {b, 8'h00};
	// sum including this byte (odd length padded with a zero low byte)
	assign total      = oc_add(sum_q, word);

	always_comb begin
		type_n  = type_q;
		code_n  = code_q;
		cksum_n = cksum_q;
		rest_n  = rest_q;
		if (in_header) begin
			unique case (count_q[HDR_IDX_W-1:0])
				3'd0: type_n = b;
				3'd1: code_n = b;
				3'd2: cksum_n[15:8] = b;
				3'd3: cksum_n[7:0] = b;
				3'd4: rest_n[31:24] = b;
				3'd5: rest_n[23:16] = b;
				3'd6: rest_n[15:8] = b;
				3'd7: rest_n[7:0] = b;
				default: ;
			endcase
		end
	end

	always_comb begin
		priority if (count_q < COUNT_W'(HEADER_BYTES - 1)) status = STATUS_SHORT;
		else if (total != SUM_GOOD) status = STATUS_MISMATCH;
		else status = STATUS_OK;
	end

	always_comb begin
		push_data.has_payload = is_payload;
		push_data.has_verdict = msg.end_of_message;
		push_data.data_byte   = b;
		push_data.status      = status;
		if (status == STATUS_SHORT) begin
			push_data.msg_type       = '0;
			push_data.msg_code       = '0;
			push_data.checksum_field = '0;
			push_data.rest_word      = '0;
		end else begin
			push_data.msg_type       = type_n;
			push_data.msg_code       = code_n;
			push_data.checksum_field = cksum_n;
			push_data.rest_word      = rest_n;
		end
	end

	// header bytes that do not end a message cause no result
	assign push = accept && (is_payload || msg.end_of_message);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			held_q  <= '0;
			type_q  <= '0;
			code_q  <= '0;
			cksum_q <= '0;
			rest_q  <= '0;
		end else if (accept) begin
			type_q  <= type_n;
			code_q  <= code_n;
			cksum_q <= cksum_n;
			rest_q  <= rest_n;
			if (!odd) held_q <= b;
			if (msg.end_of_message) begin
				count_q <= '0;
				sum_q   <= '0;
			end else begin
				// saturate by toggling the low bit so word pairing stays right
				count_q <= (count_q == COUNT_MAX) ? COUNT_WRAP : count_q + 1'b1;
				if (odd) sum_q <= total;
			end
		end
	end

endmodule

// File: rtl/core/icrc_queue.sv
// short queue between front and back
module icrc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  icrc_pkg::work_t push_data,
	output logic            full,
	output logic            head_valid,
	output icrc_pkg::work_t head_data,
	input  logic            pop
);
	import icrc_pkg::*;

	work_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	assign full       = count_q == QCNT_W'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			unique case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/core/icrc_back.sv
// back end: turns queued work into payload and verdict items
module icrc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  icrc_pkg::work_t head_data,
	output logic            pop,
	icrc_out_if.source      result
);
	import icrc_pkg::*;

	logic        valid_q;
	logic        phase_q;
	kind_t       kind_q;
	logic [7:0]  byte_q;
	logic [7:0]  type_q;
	logic [7:0]  code_q;
	logic [15:0] cksum_q;
	logic [31:0] rest_q;
	status_t     status_q;
	logic        last_q;

	logic        load;
	logic        emit_payload;

	assign load         = head_valid && (!valid_q || result.ready);
	assign emit_payload = head_data.has_payload && !phase_q;
	// entry with both results stays for a second turn
	assign pop          = load && !(emit_payload && head_data.has_verdict);

	assign result.valid          = valid_q;
	assign result.kind           = kind_q;
	assign result.payload_byte   = byte_q;
	assign result.msg_type       = type_q;
	assign result.msg_code       = code_q;
	assign result.checksum_field = cksum_q;
	assign result.rest_word      = rest_q;
	assign result.status         = status_q;
	assign result.run_last       = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			if (load) valid_q <= 1'b1;
			else if (result.ready) valid_q <= 1'b0;
			if (load) phase_q <= emit_payload && head_data.has_verdict;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (emit_payload) begin
				kind_q   <= KIND_PAYLOAD;
				byte_q   <= head_data.data_byte;
				type_q   <= '0;
				code_q   <= '0;
				cksum_q  <= '0;
				rest_q   <= '0;
				status_q <= STATUS_OK;
				last_q   <= !head_data.has_verdict;
			end else begin
				kind_q   <= KIND_VERDICT;
				byte_q   <= '0;
				type_q   <= head_data.msg_type;
				code_q   <= head_data.msg_code;
				cksum_q  <= head_data.checksum_field;
				rest_q   <= head_data.rest_word;
				status_q <= head_data.status;
				last_q   <= 1'b1;
			end
		end
	end

endmodule

// File: rtl/core/icmp_receive_checker.sv
// icmp receive checker top level
// a byte's items pass through the work queue and then the back's output register
// one byte per cycle while the work queue is not full; a final payload byte yields a payload item, then its verdict
// the four-entry work queue drops msg.ready when full, so a stalled output backs up
// arst_n clears byte count, running sum, captured header, queue and output valid
module icmp_receive_checker (
	input  logic       clk,
	input  logic       arst_n,
	icrc_in_if.sink    msg,
	icrc_out_if.source result
);
	import icrc_pkg::*;

	// front to queue
	logic  push;
	work_t push_data;
	logic  queue_full;

	// queue to back
	logic  head_valid;
	work_t head_data;
	logic  pop;

	// front: counts bytes, folds the checksum, captures the header and
	// decides which items each byte causes
	icrc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg       (msg),
		.queue_full(queue_full),
		.push      (push),
		.push_data (push_data)
	);

	// decouples the byte stream from output stalls
	icrc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (queue_full),
		.head_valid(head_valid),
		.head_data (head_data),
		.pop       (pop)
	);

	// back: registered output, payload item first then verdict
	icrc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head_data (head_data),
		.pop       (pop),
		.result    (result)
	);

endmodule

// File: rtl/core/icrc_checker.sv
// port-level assertions for the icmp receive checker, bound to the top level
module icrc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic        res_kind,
	input logic [7:0]  res_payload_byte,
	input logic [7:0]  res_msg_type,
	input logic [7:0]  res_msg_code,
	input logic [15:0] res_checksum_field,
	input logic [31:0] res_rest_word,
	input logic [1:0]  res_status,
	input logic        res_run_last
);
	import icrc_pkg::*;

	// stalled item holds
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_kind)
			&& $stable(res_payload_byte) && $stable(res_status) && $stable(res_run_last))
		else $error("stalled result item changed");

	// payload item carries no header or status
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_kind == KIND_PAYLOAD |-> res_status == STATUS_OK
			&& res_msg_type == '0 && res_msg_code == '0
			&& res_checksum_field == '0 && res_rest_word == '0)
		else $error("payload item with header fields");

	// every verdict ends the run with no payload byte; a short one reports no type, checksum or rest word
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_kind == KIND_VERDICT |-> res_run_last && res_payload_byte == '0
			&& (res_status != STATUS_SHORT || (res_msg_type == '0
			&& res_checksum_field == '0 && res_rest_word == '0)))
		else $error("bad verdict item");

	// payload that does not end its run is followed at once by its verdict
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && res_kind == KIND_PAYLOAD && !res_run_last
			|=> res_valid && res_kind == KIND_VERDICT)
		else $error("verdict missing after final payload byte");

endmodule

bind icmp_receive_checker icrc_checker u_icrc_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.res_valid         (result.valid),
	.res_ready         (result.ready),
	.res_kind          (result.kind),
	.res_payload_byte  (result.payload_byte),
	.res_msg_type      (result.msg_type),
	.res_msg_code      (result.msg_code),
	.res_checksum_field(result.checksum_field),
	.res_rest_word     (result.rest_word),
	.res_status        (result.status),
	.res_run_last      (result.run_last)
);

// File: dv/icmp_verdict_check.sv
// watches both channels of the icmp receive checker, predicts each result item and compares
module icmp_verdict_check (
	input  logic clk,
	input  logic arst_n,
	icrc_in_if   msg,
	icrc_out_if  result,
	output int   errors,
	output int   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import icrc_pkg::*;

	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  payload_byte;
		logic [7:0]  msg_type;
		logic [7:0]  msg_code;
		logic [15:0] checksum_field;
		logic [31:0] rest_word;
		status_t     status;
		logic        run_last;
	} icmp_item_t;

	icmp_item_t due_items[$];

	logic [COUNT_W-1:0] byte_offset;
	logic [SUM_W-1:0]   word_sum;
	logic [7:0]         high_byte;
	logic [7:0]         hdr_type;
	logic [7:0]         hdr_code;
	logic [15:0]        hdr_csum;
	logic [31:0]        hdr_rest;
	int                 fails;

	function automatic logic [15:0] ones_add(logic [15:0] a, logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[15:0] + {15'd0, s[16]};
	endfunction

	function automatic string describe(icmp_item_t it);
		return $sformatf({"kind=%0d byte=%02h type=%02h code=%02h csum=%04h",
			" rest=%08h st=%0d last=%0b"},
			it.kind, it.payload_byte, it.msg_type, it.msg_code, it.checksum_field,
			it.rest_word, it.status, it.run_last);
	endfunction

	// one accepted byte: update header capture and sum, queue what it causes
	task automatic absorb_byte(logic [7:0] b, logic eom);
		icmp_item_t       it;
		logic [15:0]      total;
		logic [COUNT_W-1:0] off;
		off = byte_offset;
		case (off)
			16'd0: hdr_type = b;
			16'd1: hdr_code = b;
			16'd2: hdr_csum[15:8] = b;
			16'd3: hdr_csum[7:0] = b;
			16'd4: hdr_rest[31:24] = b;
			16'd5: hdr_rest[23:16] = b;
			16'd6: hdr_rest[15:8] = b;
			16'd7: hdr_rest[7:0] = b;
			default: ;
		endcase
		if (!off[0]) begin
			high_byte = b;
		end else begin
			word_sum = ones_add(word_sum, {high_byte, b});
		end
		// counter parks on the top two values so the low bit keeps pairing bytes
		byte_offset = (off == COUNT_MAX) ? COUNT_WRAP : off + 16'd1;
		if (off >= HEADER_BYTES) begin
			it = '0;
			it.kind = KIND_PAYLOAD;
			it.payload_byte = b;
			it.status = STATUS_OK;
			it.run_last = !eom;
			due_items.push_back(it);
		end
		if (eom) begin
			total = word_sum;
			if (!off[0]) begin
				total = ones_add(total, {b, 8'h00});
			end
			it = '0;
			it.kind = KIND_VERDICT;
			it.run_last = 1'b1;
			if (off < HEADER_BYTES - 1) begin
				it.status = STATUS_SHORT;
			end else begin
				it.status = (total == SUM_GOOD) ? STATUS_OK : STATUS_MISMATCH;
				it.msg_type = hdr_type;
				it.msg_code = hdr_code;
				it.checksum_field = hdr_csum;
				it.rest_word = hdr_rest;
			end
			due_items.push_back(it);
			byte_offset = '0;
			word_sum = '0;
		end
	endtask

	task automatic compare_item();
		icmp_item_t got;
		icmp_item_t want;
		string      diff;
		got.kind = kind_t'(result.kind);
		got.payload_byte = result.payload_byte;
		got.msg_type = result.msg_type;
		got.msg_code = result.msg_code;
		got.checksum_field = result.checksum_field;
		got.rest_word = result.rest_word;
		got.status = status_t'(result.status);
		got.run_last = result.run_last;
		if (due_items.size() == 0) begin
			fails++;
			if (fails <= REPORT_LIMIT)
				$display("%0t unexpected item: %s", $realtime, describe(got));
			return;
		end
		want = due_items.pop_front();
		diff = "";
		if (got.kind !== want.kind) diff = {diff, " kind"};
		if (got.payload_byte !== want.payload_byte) diff = {diff, " payload_byte"};
		if (got.msg_type !== want.msg_type) diff = {diff, " msg_type"};
		if (got.msg_code !== want.msg_code) diff = {diff, " msg_code"};
		if (got.checksum_field !== want.checksum_field) diff = {diff, " checksum_field"};
		if (got.rest_word !== want.rest_word) diff = {diff, " rest_word"};
		if (got.status !== want.status) diff = {diff, " status"};
		if (got.run_last !== want.run_last) diff = {diff, " run_last"};
		if (diff != "") begin
			fails++;
			if (fails <= REPORT_LIMIT)
				$display("%0t mismatch in%s\n  expected %s\n  actual   %s", $realtime, diff,
					describe(want), describe(got));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			due_items.delete();
			byte_offset = '0;
			word_sum = '0;
			high_byte = '0;
			hdr_type = '0;
			hdr_code = '0;
			hdr_csum = '0;
			hdr_rest = '0;
			fails = 0;
			errors <= 0;
			outstanding <= 0;
		end else begin
			if (msg.valid && msg.ready)
				absorb_byte(msg.data_byte, msg.end_of_message);
			if (result.valid && result.ready)
				compare_item();
			errors <= fails;
			outstanding <= due_items.size();
		end
	end

endmodule

// File: dv/tb_icmp_receive_checker.sv
// stimulus and verdict for the icmp receive checker
module tb_icmp_receive_checker;
	timeunit 1ns;
	timeprecision 1ps;
	import icrc_pkg::*;

	localparam int RANDOM_BYTES = 1450;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit   steady;        // when set, neither side inserts gaps
	int   mismatches;
	int   in_flight;
	int   idle_cycles;
	logic [7:0] msg_bytes[$];

	icrc_in_if  msg();
	icrc_out_if result();

	icmp_receive_checker dut (
		.clk(clk),
		.arst_n(arst_n),
		.msg(msg),
		.result(result)
	);

	icmp_verdict_check verdict_check (
		.clk(clk),
		.arst_n(arst_n),
		.msg(msg),
		.result(result),
		.errors(mismatches),
		.outstanding(in_flight)
	);

	always #6 clk = ~clk;

	// fill the message buffer, fill < 0 means random bytes
	function automatic void build_message(int len, int fill);
		msg_bytes.delete();
		repeat (len) msg_bytes.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
	endfunction

	// write bytes 2 and 3 so the whole message sums to all ones
	function automatic void seal_checksum();
		logic [31:0] acc;
		logic [7:0]  lo;
		acc = '0;
		msg_bytes[2] = 8'h00;
		msg_bytes[3] = 8'h00;
		for (int i = 0; i < msg_bytes.size(); i += 2) begin
			lo = (i + 1 < msg_bytes.size()) ? msg_bytes[i+1] : 8'h00;
			acc += {16'h0000, msg_bytes[i], lo};
		end
		while (acc[31:16] != 16'h0000)
			acc = {16'h0000, acc[15:0]} + {16'h0000, acc[31:16]};
		{msg_bytes[2], msg_bytes[3]} = ~acc[15:0];
	endfunction

	// push the buffer into the block, one byte per item, last byte flagged
	task automatic send_message();
		int gap;
		foreach (msg_bytes[i]) begin
			gap = steady ? 0 : $urandom_range(0, 8);
			if (gap != 0) begin
				msg.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			msg.valid <= 1'b1;
			msg.data_byte <= msg_bytes[i];
			msg.end_of_message <= (i == msg_bytes.size() - 1);
			do @(posedge clk); while (!msg.ready);
		end
	endtask

	// output side: random stall before each item, none while steady
	initial begin : drain_side
		int stall;
		result.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 8);
			if (stall != 0) begin
				result.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result.ready <= 1'b1;
			do @(posedge clk); while (!result.valid);
		end
	end

	// watchdog: too long without any item moving on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((msg.valid && msg.ready) || (result.valid && result.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end else begin
			idle_cycles <= 0;
		end
	end

	initial begin : stimulus
		int sent;
		int pick;
		int len;
		msg.valid <= 1'b0;
		msg.data_byte <= 8'h00;
		msg.end_of_message <= 1'b0;
		steady = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single byte: short, header fields forced to zero in the verdict
		build_message(1, 8'hFF);
		send_message();
		// one byte short of a full header
		build_message(7, 8'hFF);
		send_message();
		// exact header length, all zero: zero sum must read as a mismatch
		build_message(8, 8'h00);
		send_message();
		// odd length with one payload byte: payload and verdict from the last byte
		build_message(9, 8'hFF);
		seal_checksum();
		send_message();

		sent = 0;
		while (sent < RANDOM_BYTES) begin
			pick = $urandom_range(0, 99);
			len = $urandom_range(8, 40);
			steady = ($urandom_range(0, 5) == 0);
			if (pick < 60) begin
				build_message(len, -1);
				seal_checksum();
			end else if (pick < 72) begin
				// good message with one flipped bit
				build_message(len, -1);
				seal_checksum();
				msg_bytes[$urandom_range(0, len - 1)] ^= 8'(1 << $urandom_range(0, 7));
			end else if (pick < 84) begin
				build_message($urandom_range(1, 7), -1);
			end else if (pick < 92) begin
				build_message(len, -1);
			end else begin
				// constant fill, sealed or not
				build_message($urandom_range(8, 12), $urandom_range(0, 1) ? 8'hFF : 8'h00);
				if ($urandom_range(0, 1))
					seal_checksum();
			end
			send_message();
			sent += msg_bytes.size();
		end
		steady = 1'b0;
		msg.valid <= 1'b0;

		// let the outstanding count include the items of the last byte before waiting on it
		@(posedge clk);
		while (in_flight != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && in_flight == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// File: icmp_receive_checker.f
rtl/core/icrc_pkg.sv
rtl/core/icrc_in_if.sv
rtl/core/icrc_out_if.sv
rtl/core/icrc_front.sv
rtl/core/icrc_queue.sv
rtl/core/icrc_back.sv
rtl/core/icmp_receive_checker.sv
rtl/core/icrc_checker.sv
dv/icmp_verdict_check.sv
dv/tb_icmp_receive_checker.sv
